FILE: hdl/kal_pkg.sv
// Package for the keyed array list: capacity constants, request codes,
// entry and transfer structs and the sequencer state type. No dependencies.
`default_nettype none

package kal_pkg;

    localparam int C_CAPACITY = 64;
    localparam int C_ADDR_W   = $clog2(C_CAPACITY);
    localparam int C_CNT_W    = 7;

    typedef enum logic [2:0] {
        REQ_APPEND       = 3'd0,
        REQ_SEARCH       = 3'd1,
        REQ_DELETE       = 3'd2,
        REQ_CURSOR_START = 3'd3,
        REQ_ADVANCE      = 3'd4,
        REQ_READ         = 3'd5,
        REQ_OVERWRITE    = 3'd6
    } t_req_code;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        t_req_code   req_type;
        logic [15:0] entry_key;
        logic [31:0] entry_payload;
    } t_req;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [15:0]        out_key;
        logic [31:0]        out_payload;
        logic [C_CNT_W-1:0] entry_count;
        logic [C_CNT_W-1:0] cursor_pos;
        logic               list_full;
        logic               at_last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_SHIFT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/kal_store.sv
// Entry store: one write port, one read port with registered read data.
// Depends on kal_pkg.
`default_nettype none

module kal_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [kal_pkg::C_ADDR_W-1:0] i_waddr,
    input  wire kal_pkg::t_entry              i_wdata,
    input  wire logic [kal_pkg::C_ADDR_W-1:0] i_raddr,
    output kal_pkg::t_entry                   o_rdata
);

    kal_pkg::t_entry r_mem [kal_pkg::C_CAPACITY];
    kal_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/keyed_array_list_with_cursor.sv
// Keyed array list with cursor: sequencer, key comparator and result register.
// Depends on kal_pkg and kal_store.
//
// Usage: present a request on i_req and raise start; it is taken at a rising
// edge where start is high and busy is low. Each request gives exactly one
// result on o_result, shown for one cycle with o_done high; the receiver
// cannot stall, so each result must be taken in that cycle.
// Steps from transfer to o_done:
//   append, cursor to start, advance, overwrite, rejected requests: no busy state
//   read at cursor: registered read of the entry store in ST_READ
//   search: in ST_SEARCH, one stored entry compared per cycle up to a key hit
//   delete: in ST_SHIFT, one entry moved down per cycle from cursor + 1 on
// The single read/write port pair of the entry store and the one key
// comparator set this pacing; busy is high while a search, delete or read
// is in progress. Busy is low again in the cycle o_done rises, so the next
// request may be taken then; requests that never raise busy run one per cycle.
// After reset the list is empty and the cursor is zero; the
// entry store needs no clearing and a request may start at once.
`default_nettype none

module keyed_array_list_with_cursor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire kal_pkg::t_req i_req,
    output logic            busy,
    output logic            o_done,
    output kal_pkg::t_result o_result
);

    localparam int CW = kal_pkg::C_CNT_W;
    localparam int AW = kal_pkg::C_ADDR_W;
    localparam logic [CW-1:0] CAP = CW'(kal_pkg::C_CAPACITY);

    kal_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [CW-1:0]    r_idx, n_idx;
    logic [15:0]      r_key;
    logic             r_done;
    kal_pkg::t_result r_result;

    logic             accept;
    logic             cur_valid;
    logic             cur_last;
    logic             idx_last;
    logic             key_hit;
    logic [CW-1:0]    idx_inc;

    logic             we;
    logic [AW-1:0]    waddr;
    kal_pkg::t_entry  wdata;
    logic [AW-1:0]    raddr;
    kal_pkg::t_entry  rdata;

    logic             fin;
    logic             f_status;
    logic             f_found;
    logic [15:0]      f_key;
    logic [31:0]      f_payload;

    kal_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign busy      = (r_state != kal_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cur_valid = (r_cursor < r_count);
    assign cur_last  = (CW'(r_cursor + CW'(1)) == r_count);
    assign idx_inc   = CW'(r_idx + CW'(1));
    assign idx_last  = (idx_inc == r_count);
    assign key_hit   = (rdata.key == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kal_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        kal_pkg::REQ_SEARCH: begin
                            if (r_count != '0) n_state = kal_pkg::ST_SEARCH;
                        end
                        kal_pkg::REQ_DELETE: begin
                            if (cur_valid && !cur_last) n_state = kal_pkg::ST_SHIFT;
                        end
                        kal_pkg::REQ_READ: begin
                            if (cur_valid) n_state = kal_pkg::ST_READ;
                        end
                        default: n_state = kal_pkg::ST_IDLE;
                    endcase
                end
            end
            kal_pkg::ST_READ: n_state = kal_pkg::ST_IDLE;
            kal_pkg::ST_SEARCH: begin
                if (key_hit || idx_last) n_state = kal_pkg::ST_IDLE;
            end
            kal_pkg::ST_SHIFT: begin
                if (idx_last) n_state = kal_pkg::ST_IDLE;
            end
            default: n_state = kal_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_idx     = r_idx;
        we        = 1'b0;
        waddr     = r_cursor[AW-1:0];
        wdata     = '{key: i_req.entry_key, payload: i_req.entry_payload};
        raddr     = r_idx[AW-1:0];
        fin       = 1'b0;
        f_status  = 1'b0;
        f_found   = 1'b0;
        f_key     = '0;
        f_payload = '0;
        case (r_state)
            kal_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        kal_pkg::REQ_APPEND: begin
                            fin = 1'b1;
                            if (r_count < CAP) begin
                                we      = 1'b1;
                                waddr   = r_count[AW-1:0];
                                n_count = CW'(r_count + CW'(1));
                            end else begin
                                f_status = 1'b1;
                            end
                        end
                        kal_pkg::REQ_SEARCH: begin
                            raddr = '0;
                            n_idx = '0;
                            if (r_count == '0) fin = 1'b1;
                        end
                        kal_pkg::REQ_DELETE: begin
                            if (!cur_valid) begin
                                fin      = 1'b1;
                                f_status = 1'b1;
                            end else if (cur_last) begin
                                fin     = 1'b1;
                                n_count = CW'(r_count - CW'(1));
                            end else begin
                                n_idx = CW'(r_cursor + CW'(1));
                                raddr = n_idx[AW-1:0];
                            end
                        end
                        kal_pkg::REQ_CURSOR_START: begin
                            fin      = 1'b1;
                            n_cursor = '0;
                        end
                        kal_pkg::REQ_ADVANCE: begin
                            fin = 1'b1;
                            if (r_cursor < CAP) n_cursor = CW'(r_cursor + CW'(1));
                        end
                        kal_pkg::REQ_READ: begin
                            raddr = r_cursor[AW-1:0];
                            if (!cur_valid) begin
                                fin      = 1'b1;
                                f_status = 1'b1;
                            end
                        end
                        kal_pkg::REQ_OVERWRITE: begin
                            fin = 1'b1;
                            if (cur_valid) begin
                                we = 1'b1;
                            end else begin
                                f_status = 1'b1;
                            end
                        end
                        default: begin
                            fin      = 1'b1;
                            f_status = 1'b1;
                        end
                    endcase
                end
            end
            kal_pkg::ST_READ: begin
                fin       = 1'b1;
                f_key     = rdata.key;
                f_payload = rdata.payload;
            end
            kal_pkg::ST_SEARCH: begin
                if (key_hit) begin
                    fin      = 1'b1;
                    f_found  = 1'b1;
                    n_cursor = r_idx;
                end else if (idx_last) begin
                    fin = 1'b1;
                end else begin
                    n_idx = idx_inc;
                    raddr = idx_inc[AW-1:0];
                end
            end
            kal_pkg::ST_SHIFT: begin
                // move entry idx down to idx - 1
                we    = 1'b1;
                waddr = AW'(r_idx - CW'(1));
                wdata = rdata;
                if (idx_last) begin
                    fin     = 1'b1;
                    n_count = CW'(r_count - CW'(1));
                end else begin
                    n_idx = idx_inc;
                    raddr = idx_inc[AW-1:0];
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kal_pkg::ST_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_done   <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (accept) begin
            r_key <= i_req.entry_key;
        end
        if (fin) begin
            r_result.status      <= f_status;
            r_result.found       <= f_found;
            r_result.out_key     <= f_key;
            r_result.out_payload <= f_payload;
            r_result.entry_count <= n_count;
            r_result.cursor_pos  <= n_cursor;
            r_result.list_full   <= (n_count == CAP);
            r_result.at_last     <= (n_count != '0) && (n_cursor == CW'(n_count - CW'(1)));
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
